[rtl/core/cst_pkg.sv]
package cst_pkg;

  localparam int SLOTS = 8;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);

  localparam logic [7:0] COUNT_MAX = 8'd255;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_BAD_ARG  = 2'd1;
  localparam logic [1:0] ST_NOT_FOUND = 2'd2;
  localparam logic [1:0] ST_FULL     = 2'd3;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] item_kind;
    logic [7:0] amount;
  } req_t;

  typedef struct packed {
    logic [1:0] status;
    logic [7:0] total;
    logic       enough;
  } rsp_t;

  typedef struct packed {
    logic [7:0] kind;
    logic [7:0] count;
  } slot_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    slot_t            data;
  } ram_wr_t;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_SCAN   = 4'b0010,
    S_DECIDE = 4'b0100,
    S_DRAIN  = 4'b1000
  } state_t;

endpackage

[rtl/core/cst_ram.sv]
module cst_ram (
  input  logic                      clk,
  input  logic                      rst,
  input  logic [cst_pkg::IDX_W-1:0] rd_addr,
  output cst_pkg::slot_t            rd_data,
  input  cst_pkg::ram_wr_t          wr
);

  cst_pkg::slot_t               mem [cst_pkg::SLOTS];
  logic [cst_pkg::SLOTS-1:0]    valid;
  cst_pkg::slot_t               rd_q;
  logic                         rd_vld;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
    rd_q <= mem[rd_addr];
  end

  // entries never written since reset read as empty
  always_ff @(posedge clk) begin
    if (rst) begin
      valid  <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr.en) begin
        valid[wr.addr] <= 1'b1;
      end
      rd_vld <= valid[rd_addr];
    end
  end

  assign rd_data = rd_vld ? rd_q : '0;

endmodule

[rtl/core/cst_ctrl.sv]
module cst_ctrl (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  cst_pkg::req_t             req,
  output logic                      busy,
  output logic                      done,
  output cst_pkg::rsp_t             rsp,
  output logic [cst_pkg::IDX_W-1:0] rd_addr,
  input  cst_pkg::slot_t            rd_data,
  output cst_pkg::ram_wr_t          wr
);

  localparam logic [cst_pkg::IDX_W-1:0] LAST_IDX = cst_pkg::IDX_W'(cst_pkg::SLOTS - 1);
  localparam logic [cst_pkg::CNT_W-1:0] NUM_SLOTS = cst_pkg::CNT_W'(cst_pkg::SLOTS);

  cst_pkg::state_t             state;
  cst_pkg::req_t               req_q;
  logic [cst_pkg::CNT_W-1:0]   rd_cnt;
  logic                        vld;
  logic [cst_pkg::IDX_W-1:0]   idx_q;
  logic [7:0]                  total;
  logic                        mfound;
  logic [cst_pkg::IDX_W-1:0]   midx;
  logic [7:0]                  mcount;
  logic                        efound;
  logic [cst_pkg::IDX_W-1:0]   eidx;
  logic [7:0]                  left;

  logic          hit;
  logic          empty;
  logic          last;
  logic [8:0]    sum9;
  logic [8:0]    add9;
  logic          add_ok;
  logic          rem_ok;
  logic          take;
  logic          issue;
  logic          scan_rd;
  cst_pkg::rsp_t dec_rsp;

  assign busy    = (state != cst_pkg::S_IDLE);
  assign rd_addr = rd_cnt[cst_pkg::IDX_W-1:0];
  assign issue   = (rd_cnt < NUM_SLOTS);
  assign scan_rd = ((state == cst_pkg::S_SCAN) || (state == cst_pkg::S_DRAIN)) && issue;

  assign hit   = vld && (req_q.item_kind != 8'd0) && (rd_data.kind == req_q.item_kind);
  assign empty = vld && (rd_data.kind == 8'd0);
  assign last  = vld && (idx_q == LAST_IDX);
  assign sum9  = {1'b0, total} + {1'b0, rd_data.count};
  assign add9  = {1'b0, mcount} + {1'b0, req_q.amount};
  assign take  = hit && (left != 8'd0);

  assign add_ok = (req_q.req_type == cst_pkg::OP_ADD) && (req_q.item_kind != 8'd0) &&
                  (req_q.amount != 8'd0);
  assign rem_ok = (req_q.req_type == cst_pkg::OP_REMOVE) && (req_q.amount != 8'd0) &&
                  (total >= req_q.amount);

  always_comb begin
    wr = '0;
    case (state)
      cst_pkg::S_DECIDE: begin
        if (add_ok && mfound) begin
          wr.en         = 1'b1;
          wr.addr       = midx;
          wr.data.kind  = req_q.item_kind;
          wr.data.count = add9[8] ? cst_pkg::COUNT_MAX : add9[7:0];
        end else if (add_ok && efound) begin
          wr.en         = 1'b1;
          wr.addr       = eidx;
          wr.data.kind  = req_q.item_kind;
          wr.data.count = req_q.amount;
        end
      end
      cst_pkg::S_DRAIN: begin
        if (take) begin
          wr.en   = 1'b1;
          wr.addr = idx_q;
          if (rd_data.count > left) begin
            wr.data.kind  = rd_data.kind;
            wr.data.count = rd_data.count - left;
          end
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    dec_rsp = '0;
    case (req_q.req_type)
      cst_pkg::OP_ADD: begin
        if (!add_ok) begin
          dec_rsp.status = cst_pkg::ST_BAD_ARG;
        end else if (mfound || efound) begin
          dec_rsp.status = cst_pkg::ST_OK;
        end else begin
          dec_rsp.status = cst_pkg::ST_FULL;
        end
      end
      cst_pkg::OP_REMOVE: begin
        dec_rsp.status = cst_pkg::ST_NOT_FOUND;
      end
      cst_pkg::OP_QUERY: begin
        dec_rsp.status = cst_pkg::ST_OK;
        dec_rsp.total  = total;
        dec_rsp.enough = (total >= req_q.amount);
      end
      default: begin
        dec_rsp.status = cst_pkg::ST_BAD_ARG;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= cst_pkg::S_IDLE;
      done   <= 1'b0;
      vld    <= 1'b0;
      rd_cnt <= '0;
    end else begin
      done <= ((state == cst_pkg::S_DECIDE) && !rem_ok) ||
              ((state == cst_pkg::S_DRAIN) && last);
      vld  <= scan_rd;
      if (scan_rd) begin
        idx_q  <= rd_addr;
        rd_cnt <= rd_cnt + 1'b1;
      end
      case (state)
        cst_pkg::S_IDLE: begin
          if (start) begin
            req_q  <= req;
            rd_cnt <= '0;
            total  <= 8'd0;
            mfound <= 1'b0;
            efound <= 1'b0;
            state  <= cst_pkg::S_SCAN;
          end
        end
        cst_pkg::S_SCAN: begin
          if (hit) begin
            total <= sum9[8] ? cst_pkg::COUNT_MAX : sum9[7:0];
            if (!mfound) begin
              mfound <= 1'b1;
              midx   <= idx_q;
              mcount <= rd_data.count;
            end
          end
          if (empty && !efound) begin
            efound <= 1'b1;
            eidx   <= idx_q;
          end
          if (last) begin
            state <= cst_pkg::S_DECIDE;
          end
        end
        cst_pkg::S_DECIDE: begin
          if (rem_ok) begin
            rsp    <= '0;
            rd_cnt <= '0;
            left   <= req_q.amount;
            state  <= cst_pkg::S_DRAIN;
          end else begin
            rsp   <= dec_rsp;
            state <= cst_pkg::S_IDLE;
          end
        end
        cst_pkg::S_DRAIN: begin
          if (take) begin
            left <= (rd_data.count > left) ? 8'd0 : (left - rd_data.count);
          end
          if (last) begin
            rsp.status <= cst_pkg::ST_OK;
            state      <= cst_pkg::S_IDLE;
          end
        end
        default: begin
          state <= cst_pkg::S_IDLE;
        end
      endcase
    end
  end

endmodule

[rtl/core/counted_item_slot_table.sv]
// Slot table of item kinds with per-slot counts (kind 0 marks an empty slot).
// Request channel: drive req (req_type, item_kind, amount) and raise start;
// the transfer happens at the clock edge where start is high and busy is low.
// busy stays high until the request has been fully processed.
// Result channel: done pulses for one cycle with rsp (status, total, enough).
// The receiver cannot stall; rsp is only valid in the done cycle.
// Processing of add, query and a rejected remove takes one pass over the slot
// RAM plus a decision state; a remove that drains takes a totaling pass, the
// decision state and a read-modify-write drain pass. One new request may be
// taken in the same cycle done is high.
// The rate is set by the single read port of the slot RAM, read once per slot
// per pass.
// Reset (rst, synchronous) empties the table at once through per-slot valid
// bits; no clearing pass is needed and a request may follow directly.
module counted_item_slot_table (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  cst_pkg::req_t req,
  output logic          busy,
  output logic          done,
  output cst_pkg::rsp_t rsp
);

  logic [cst_pkg::IDX_W-1:0] rd_addr;
  cst_pkg::slot_t            rd_data;
  cst_pkg::ram_wr_t          wr;

  cst_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .req     (req),
    .busy    (busy),
    .done    (done),
    .rsp     (rsp),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  cst_ram u_ram (
    .clk     (clk),
    .rst     (rst),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr      (wr)
  );

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("busy not raised after request transfer");

  a_done_idle: assert property (@(posedge clk) disable iff (rst)
    done |-> !busy)
    else $error("result strobed while still busy");

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("two results in consecutive cycles");

  a_no_write_idle: assert property (@(posedge clk) disable iff (rst)
    !busy |-> !wr.en)
    else $error("slot RAM written while idle");

endmodule
